// ===== hdl/qte_pkg.sv =====
// qte_pkg: shared widths, formats, angle table and sideband types for the
// quaternion to Euler angle pipeline. No dependencies.
`default_nettype none
package qte_pkg;

	localparam int IN_W                  = 16;   // Q2.14 quaternion component
	localparam int PROD_W                = 32;   // product of two components
	localparam int OP_W                  = 34;   // atan2 operands, 1.0 = 2^28
	localparam int CW                    = 36;   // CORDIC x/y datapath
	localparam int ZW                    = 26;   // angle accumulator, deg Q16
	localparam int RAD_W                 = 57;   // 1 - s^2, 1.0 = 2^56
	localparam int REM_W                 = 58;   // square root remainder
	localparam int ROOT_W                = 29;   // square root result
	localparam int ATAN_TABLE_LEN        = 24;
	localparam int CORDIC_ITERATIONS_DEF = 16;

	localparam logic signed [OP_W-1:0] ONE_Q28      = 34'sh0_1000_0000;
	localparam logic signed [OP_W-1:0] NEG_ONE_Q28  = -34'sh0_1000_0000;
	localparam logic [RAD_W-1:0]       ONE_Q56      = 57'h100_0000_0000_0000;
	localparam logic signed [ZW-1:0]   QUARTER_Q16  = 26'sd5898240;
	localparam logic signed [ZW-1:0]   RND_HALF     = 26'sd512;

	localparam logic signed [15:0] ROLL_LIMIT  = 16'sd11520;
	localparam logic signed [15:0] PITCH_LIMIT = 16'sd5760;
	localparam logic signed [15:0] FULL_TURN   = 16'sd23040;

	typedef struct packed {
		logic clamped;   // |s| reached one
		logic neg;       // sign of s
	} pitch_ctl_t;

	typedef struct packed {
		pitch_ctl_t              ctl;
		logic signed [OP_W-1:0]  s;
	} pitch_tag_t;

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic logic signed [ZW-1:0] atan_deg_q16(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0:  r = 26'sd2949120;
			1:  r = 26'sd1740967;
			2:  r = 26'sd919879;
			3:  r = 26'sd466945;
			4:  r = 26'sd234379;
			5:  r = 26'sd117304;
			6:  r = 26'sd58666;
			7:  r = 26'sd29335;
			8:  r = 26'sd14668;
			9:  r = 26'sd7334;
			10: r = 26'sd3667;
			11: r = 26'sd1833;
			12: r = 26'sd917;
			13: r = 26'sd458;
			14: r = 26'sd229;
			15: r = 26'sd115;
			16: r = 26'sd57;
			17: r = 26'sd29;
			18: r = 26'sd14;
			19: r = 26'sd7;
			20: r = 26'sd4;
			21: r = 26'sd2;
			22: r = 26'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/qte_delay.sv =====
// qte_delay: enabled shift line used to line up paths of different latency.
// Depends on nothing.
`default_nettype none
module qte_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [W-1:0] din,
	output      logic [W-1:0] dout
);

	logic [W-1:0] tap_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) tap_q[i] <= '0;
		end else if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) tap_q[i] <= tap_q[i-1];
		end
	end

	assign dout = tap_q[DEPTH-1];

endmodule
`default_nettype wire

// ===== hdl/qte_front.sv =====
// qte_front: products, atan2 operands, pitch sine square and 1 - s^2.
// Depends on qte_pkg.
`default_nettype none
module qte_front import qte_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   in_valid,
	input  wire logic signed [IN_W-1:0] w,
	input  wire logic signed [IN_W-1:0] x,
	input  wire logic signed [IN_W-1:0] y,
	input  wire logic signed [IN_W-1:0] z,
	output      logic                   atan_v_s2,
	output      logic signed [OP_W-1:0] roll_y_s2,
	output      logic signed [OP_W-1:0] roll_x_s2,
	output      logic signed [OP_W-1:0] yaw_y_s2,
	output      logic signed [OP_W-1:0] yaw_x_s2,
	output      logic                   sqrt_v_s4,
	output      logic [RAD_W-1:0]       rad_s4,
	output      pitch_tag_t             tag_s4
);

	logic                     v_s1, v_s3;
	logic signed [PROD_W-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	logic signed [OP_W-1:0]   ry_c, rx_c, yy_c, yx_c, s_c;
	pitch_tag_t               tag_s2, tag_s3;
	logic signed [ROOT_W-1:0] s_lo;
	logic signed [REM_W-1:0]  sq_c;
	logic [RAD_W-2:0]         sq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			atan_v_s2 <= 1'b0;
			v_s3      <= 1'b0;
			sqrt_v_s4 <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			atan_v_s2 <= v_s1;
			v_s3      <= atan_v_s2;
			sqrt_v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= w * x;
			yz_s1 <= y * z;
			xx_s1 <= x * x;
			yy_s1 <= y * y;
			wy_s1 <= w * y;
			zx_s1 <= z * x;
			wz_s1 <= w * z;
			xy_s1 <= x * y;
			zz_s1 <= z * z;
		end
	end

	always_comb begin
		ry_c = (OP_W'(wx_s1) + OP_W'(yz_s1)) <<< 1;
		rx_c = ONE_Q28 - ((OP_W'(xx_s1) + OP_W'(yy_s1)) <<< 1);
		yy_c = (OP_W'(wz_s1) + OP_W'(xy_s1)) <<< 1;
		yx_c = ONE_Q28 - ((OP_W'(yy_s1) + OP_W'(zz_s1)) <<< 1);
		s_c  = (OP_W'(wy_s1) - OP_W'(zx_s1)) <<< 1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_y_s2          <= ry_c;
			roll_x_s2          <= rx_c;
			yaw_y_s2           <= yy_c;
			yaw_x_s2           <= yx_c;
			tag_s2.s           <= s_c;
			tag_s2.ctl.clamped <= (s_c >= ONE_Q28) || (s_c <= NEG_ONE_Q28);
			tag_s2.ctl.neg     <= s_c[OP_W-1];
		end
	end

	// only meaningful when |s| < 1, where s fits the narrow operand
	assign s_lo = tag_s2.s[ROOT_W-1:0];
	assign sq_c = s_lo * s_lo;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3  <= sq_c[RAD_W-2:0];
			tag_s3 <= tag_s2;
			rad_s4 <= ONE_Q56 - RAD_W'(sq_s3);
			tag_s4 <= tag_s3;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/qte_isqrt.sv =====
// qte_isqrt: pipelined digit-by-digit integer square root, one result bit
// per stage, with the pitch sideband carried alongside. Depends on qte_pkg.
`default_nettype none
module qte_isqrt import qte_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [RAD_W-1:0]  rad,
	input  wire pitch_tag_t        tag_in,
	output      logic              out_valid,
	output      logic [ROOT_W-1:0] root,
	output      pitch_tag_t        tag_out
);

	logic             v_s   [ROOT_W+1];
	logic [REM_W-1:0] rem_s [ROOT_W+1];
	logic [REM_W-1:0] res_s [ROOT_W+1];
	pitch_tag_t       tag_s [ROOT_W+1];

	assign v_s[0]   = in_valid;
	assign rem_s[0] = REM_W'(rad);
	assign res_s[0] = '0;
	assign tag_s[0] = tag_in;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam logic [REM_W-1:0] BITV = REM_W'(1) << (2 * (ROOT_W - 1 - k));
		logic [REM_W-1:0] trial;
		logic             take;

		assign trial = res_s[k] + BITV;
		assign take  = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (en) v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? rem_s[k] - trial : rem_s[k];
				res_s[k+1] <= take ? (res_s[k] >> 1) + BITV : res_s[k] >> 1;
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign root      = res_s[ROOT_W][ROOT_W-1:0];
	assign tag_out   = tag_s[ROOT_W];

endmodule
`default_nettype wire

// ===== hdl/qte_cordic.sv =====
// qte_cordic: pipelined CORDIC vectoring atan2 in degrees (Q16), a fold
// stage into the right half plane, then one stage per iteration.
// Depends on qte_pkg.
`default_nettype none
module qte_cordic import qte_pkg::*; #(
	parameter int ITER = CORDIC_ITERATIONS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic signed [CW-1:0] y_in,
	input  wire logic signed [CW-1:0] x_in,
	output      logic                 out_valid,
	output      logic signed [ZW-1:0] angle
);

	localparam int N = (ITER > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN : ITER;

	logic                 v_s  [N+1];
	logic                 zf_s [N+1];
	logic signed [CW-1:0] x_s  [N+1];
	logic signed [CW-1:0] y_s  [N+1];
	logic signed [ZW-1:0] z_s  [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zf_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_s[0] <= y_in;
					y_s[0] <= -x_in;
					z_s[0] <= QUARTER_Q16;
				end else begin
					x_s[0] <= -y_in;
					y_s[0] <= x_in;
					z_s[0] <= -QUARTER_Q16;
				end
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		localparam logic signed [ZW-1:0] ATAN_I = atan_deg_q16(i);
		logic signed [CW-1:0] dx, dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else if (en) v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zf_s[i+1] <= zf_s[i];
				if (y_s[i] < 0) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ATAN_I;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ATAN_I;
				end
			end
		end
	end

	assign out_valid = v_s[N];
	assign angle     = zf_s[N] ? '0 : z_s[N];

endmodule
`default_nettype wire

// ===== hdl/quaternion_to_euler_degrees.sv =====
// Channel   Valid        Stall        Payload
// quat      quat_valid   quat_stall   quat_w, quat_x, quat_y, quat_z (Q2.14)
// euler     euler_valid  euler_stall  roll_angle, pitch_angle, yaw_angle,
//                                     pitch_clamped (1/64 degree)
//
// One item per cycle unless the output stalls. N = min(CORDIC_ITERATIONS, 24):
// four front stages, 29 square root stages, N + 1 pitch CORDIC stages and the
// output register. The pitch square root sets the depth; roll and yaw are
// delayed to match. Reset clears only valid bits and delay lines. A stalled
// output freezes the whole pipeline; quat_stall follows it in the same cycle.
//
// Top level of the quaternion to Euler pipeline. Depends on qte_pkg,
// qte_front, qte_isqrt, qte_cordic and qte_delay.
`default_nettype none
module quaternion_to_euler_degrees import qte_pkg::*; #(
	parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   quat_valid,
	output      logic                   quat_stall,
	input  wire logic signed [IN_W-1:0] quat_w,
	input  wire logic signed [IN_W-1:0] quat_x,
	input  wire logic signed [IN_W-1:0] quat_y,
	input  wire logic signed [IN_W-1:0] quat_z,
	output      logic                   euler_valid,
	input  wire logic                   euler_stall,
	output      logic signed [14:0]     roll_angle,
	output      logic signed [13:0]     pitch_angle,
	output      logic [14:0]            yaw_angle,
	output      logic                   pitch_clamped
);

	localparam int NEFF    = (CORDIC_ITERATIONS > ATAN_TABLE_LEN) ?
	                         ATAN_TABLE_LEN : CORDIC_ITERATIONS;
	localparam int RY_SKEW = ROOT_W + 2;   // s3, s4 and the square root
	localparam int RY_W    = 2 * (ZW + 1);
	localparam int CTL_W   = $bits(pitch_ctl_t);

	logic                   en;
	logic                   atan_v_s2, sqrt_v_s4, root_v, roll_v, yaw_v, pitch_v;
	logic signed [OP_W-1:0] roll_y_s2, roll_x_s2, yaw_y_s2, yaw_x_s2;
	logic [RAD_W-1:0]       rad_s4;
	pitch_tag_t             tag_s4, root_tag;
	logic [ROOT_W-1:0]      root;
	logic signed [ZW-1:0]   roll_z, yaw_z, pitch_z, roll_zd, yaw_zd;
	logic                   roll_vd, yaw_vd;
	logic [CTL_W-1:0]       ctl_bits_d;
	pitch_ctl_t             ctl_d;
	logic signed [ZW-1:0]   roll_b, pitch_b, yaw_b;
	logic signed [15:0]     roll_r, pitch_r, yaw_r, roll_c, pitch_c, yaw_c;
	logic                   euler_valid_q;
	logic signed [14:0]     roll_q;
	logic signed [13:0]     pitch_q;
	logic [14:0]            yaw_q;
	logic                   clamped_q;

	assign quat_stall = euler_valid_q && euler_stall;
	assign en         = !quat_stall;

	qte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (quat_valid),
		.w         (quat_w),
		.x         (quat_x),
		.y         (quat_y),
		.z         (quat_z),
		.atan_v_s2 (atan_v_s2),
		.roll_y_s2 (roll_y_s2),
		.roll_x_s2 (roll_x_s2),
		.yaw_y_s2  (yaw_y_s2),
		.yaw_x_s2  (yaw_x_s2),
		.sqrt_v_s4 (sqrt_v_s4),
		.rad_s4    (rad_s4),
		.tag_s4    (tag_s4)
	);

	qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (atan_v_s2),
		.y_in      (CW'(roll_y_s2)),
		.x_in      (CW'(roll_x_s2)),
		.out_valid (roll_v),
		.angle     (roll_z)
	);

	qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (atan_v_s2),
		.y_in      (CW'(yaw_y_s2)),
		.x_in      (CW'(yaw_x_s2)),
		.out_valid (yaw_v),
		.angle     (yaw_z)
	);

	qte_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sqrt_v_s4),
		.rad       (rad_s4),
		.tag_in    (tag_s4),
		.out_valid (root_v),
		.root      (root),
		.tag_out   (root_tag)
	);

	qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (root_v),
		.y_in      (CW'(root_tag.s)),
		.x_in      (signed'(CW'(root))),
		.out_valid (pitch_v),
		.angle     (pitch_z)
	);

	qte_delay #(.W(CTL_W), .DEPTH(NEFF + 1)) u_ctl_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (root_tag.ctl),
		.dout   (ctl_bits_d)
	);
	assign ctl_d = pitch_ctl_t'(ctl_bits_d);

	qte_delay #(.W(RY_W), .DEPTH(RY_SKEW)) u_ry_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    ({roll_v, roll_z, yaw_v, yaw_z}),
		.dout   ({roll_vd, roll_zd, yaw_vd, yaw_zd})
	);

	// round to 1/64 degree, saturate, wrap yaw
	always_comb begin
		roll_b  = roll_zd + RND_HALF;
		pitch_b = pitch_z + RND_HALF;
		yaw_b   = yaw_zd + RND_HALF;
		roll_r  = roll_b[ZW-1:10];
		pitch_r = pitch_b[ZW-1:10];
		yaw_r   = yaw_b[ZW-1:10];

		if (roll_r > ROLL_LIMIT)       roll_c = ROLL_LIMIT;
		else if (roll_r < -ROLL_LIMIT) roll_c = -ROLL_LIMIT;
		else                           roll_c = roll_r;

		if (ctl_d.clamped)               pitch_c = ctl_d.neg ? -PITCH_LIMIT : PITCH_LIMIT;
		else if (pitch_r > PITCH_LIMIT)  pitch_c = PITCH_LIMIT;
		else if (pitch_r < -PITCH_LIMIT) pitch_c = -PITCH_LIMIT;
		else                             pitch_c = pitch_r;

		if (yaw_r > ROLL_LIMIT)       yaw_c = ROLL_LIMIT;
		else if (yaw_r < -ROLL_LIMIT) yaw_c = -ROLL_LIMIT;
		else                          yaw_c = yaw_r;
		if (yaw_c < 0) yaw_c = yaw_c + FULL_TURN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) euler_valid_q <= 1'b0;
		else if (en) euler_valid_q <= pitch_v && roll_vd && yaw_vd;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_q    <= roll_c[14:0];
			pitch_q   <= pitch_c[13:0];
			yaw_q     <= yaw_c[14:0];
			clamped_q <= ctl_d.clamped;
		end
	end

	assign euler_valid   = euler_valid_q;
	assign roll_angle    = roll_q;
	assign pitch_angle   = pitch_q;
	assign yaw_angle     = yaw_q;
	assign pitch_clamped = clamped_q;

endmodule
`default_nettype wire

// ===== hdl/qte_checker.sv =====
// qte_checker: port-level checks on the quaternion to Euler pipeline, bound
// to the top level. Depends on nothing.
`default_nettype none
module qte_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               quat_valid,
	input wire logic               quat_stall,
	input wire logic signed [15:0] quat_w,
	input wire logic signed [15:0] quat_x,
	input wire logic signed [15:0] quat_y,
	input wire logic signed [15:0] quat_z,
	input wire logic               euler_valid,
	input wire logic               euler_stall,
	input wire logic signed [14:0] roll_angle,
	input wire logic signed [13:0] pitch_angle,
	input wire logic [14:0]        yaw_angle,
	input wire logic               pitch_clamped
);

	// a held result keeps its item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		euler_valid && euler_stall |=> euler_valid && $stable(roll_angle)
		&& $stable(pitch_angle) && $stable(yaw_angle) && $stable(pitch_clamped))
		else $error("result changed while stalled");

	// input backs up exactly when a result is held
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		quat_stall == (euler_valid && euler_stall))
		else $error("input stall does not follow output");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		euler_valid && pitch_clamped |-> pitch_angle == 14'sd5760
		|| pitch_angle == -14'sd5760)
		else $error("clamped pitch not at a pole");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		euler_valid |-> yaw_angle < 15'd23040 && roll_angle <= 15'sd11520
		&& roll_angle >= -15'sd11520 && pitch_angle <= 14'sd5760
		&& pitch_angle >= -14'sd5760)
		else $error("angle out of range");

endmodule

bind quaternion_to_euler_degrees qte_checker u_qte_checker (.*);
`default_nettype wire

// ===== tb/quat_euler_checker.sv =====
// quat_euler_checker: watches both channels of the quaternion to Euler block,
// predicts roll, pitch, yaw and the clamp flag, and compares in order.
// Depends on qte_pkg for the input width and the default iteration count.
module quat_euler_checker import qte_pkg::*; #(
	parameter int ITERATIONS = CORDIC_ITERATIONS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   quat_valid,
	input  logic                   quat_stall,
	input  logic signed [IN_W-1:0] quat_w,
	input  logic signed [IN_W-1:0] quat_x,
	input  logic signed [IN_W-1:0] quat_y,
	input  logic signed [IN_W-1:0] quat_z,
	input  logic                   euler_valid,
	input  logic                   euler_stall,
	input  logic signed [14:0]     roll_angle,
	input  logic signed [13:0]     pitch_angle,
	input  logic [14:0]            yaw_angle,
	input  logic                   pitch_clamped,
	output int                     errors,
	output int                     pending,
	output int                     checked,
	output int                     clamp_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [14:0] roll;
		logic signed [13:0] pitch;
		logic [14:0]        yaw;
		logic               clamped;
	} euler_t;

	localparam longint UNIT = 64'sd1 << 28;

	euler_t angle_fifo[$];

	function automatic longint atan_step(int i);
		longint steps[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
			58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
			57, 29, 14, 7, 4, 2, 1, 0};
		return steps[i];
	endfunction

	// vectoring atan2, degrees with 16 fraction bits
	function automatic longint vector_angle(longint sn, longint cs);
		longint xv, yv, zv, t, dx, dy;
		int n;
		if (sn == 0 && cs == 0)
			return 0;
		xv = cs;
		yv = sn;
		zv = 0;
		if (xv < 0) begin
			t = xv;
			if (yv >= 0) begin
				xv = yv;
				yv = -t;
				zv = 64'sd5898240;
			end else begin
				xv = -yv;
				yv = t;
				zv = -64'sd5898240;
			end
		end
		n = (ITERATIONS > 24) ? 24 : ITERATIONS;
		for (int i = 0; i < n; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv < 0) begin
				xv = xv - dx;
				yv = yv + dy;
				zv = zv - atan_step(i);
			end else begin
				xv = xv + dx;
				yv = yv - dy;
				zv = zv + atan_step(i);
			end
		end
		return zv;
	endfunction

	function automatic longint root_floor(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	function automatic longint sat_64ths(longint a, longint lim);
		longint r;
		r = (a + 512) >>> 10;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	function automatic euler_t predict_euler(longint w, longint x, longint y, longint z);
		euler_t e;
		longint r, p, yw, s;
		r = sat_64ths(vector_angle(2 * (w * x + y * z), UNIT - 2 * (x * x + y * y)), 11520);
		s = 2 * (w * y - z * x);
		e.clamped = 1'b0;
		if (s >= UNIT) begin
			p = 5760;
			e.clamped = 1'b1;
		end else if (s <= -UNIT) begin
			p = -5760;
			e.clamped = 1'b1;
		end else begin
			p = sat_64ths(vector_angle(s, root_floor((64'd1 << 56) - s * s)), 5760);
		end
		yw = sat_64ths(vector_angle(2 * (w * z + x * y), UNIT - 2 * (y * y + z * z)), 11520);
		if (yw < 0)
			yw = yw + 23040;
		if (yw >= 23040)
			yw = yw - 23040;
		e.roll = r[14:0];
		e.pitch = p[13:0];
		e.yaw = yw[14:0];
		return e;
	endfunction

	initial begin
		errors = 0;
		checked = 0;
		clamp_seen = 0;
	end

	assign pending = angle_fifo.size();

	always @(posedge clk) begin
		euler_t want;
		int bad;
		bad = 0;
		if (arst_n && euler_valid && !euler_stall) begin
			checked <= checked + 1;
			if (angle_fifo.size() == 0) begin
				$display("%0t: result with no item pending: roll %0d pitch %0d yaw %0d clamp %0b",
					$time, roll_angle, pitch_angle, yaw_angle, pitch_clamped);
				bad++;
			end else begin
				want = angle_fifo.pop_front();
				if (want.clamped)
					clamp_seen <= clamp_seen + 1;
				if (roll_angle !== want.roll) begin
					$display("%0t: roll expected %0d got %0d", $time, want.roll, roll_angle);
					bad++;
				end
				if (pitch_angle !== want.pitch) begin
					$display("%0t: pitch expected %0d got %0d", $time, want.pitch, pitch_angle);
					bad++;
				end
				if (yaw_angle !== want.yaw) begin
					$display("%0t: yaw expected %0d got %0d", $time, want.yaw, yaw_angle);
					bad++;
				end
				if (pitch_clamped !== want.clamped) begin
					$display("%0t: clamp expected %0b got %0b", $time, want.clamped,
						pitch_clamped);
					bad++;
				end
			end
			if (bad != 0)
				errors <= errors + bad;
		end
		if (arst_n && quat_valid && !quat_stall)
			angle_fifo.push_back(predict_euler(quat_w, quat_x, quat_y, quat_z));
	end

endmodule

// ===== tb/tb.sv =====
// tb: stimulus and verdict for quaternion_to_euler_degrees.
// Depends on qte_pkg, the block and quat_euler_checker.
module tb import qte_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic quat_valid = 1'b0;
	logic quat_stall;
	logic signed [IN_W-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic euler_valid;
	logic euler_stall = 1'b0;
	logic signed [14:0] roll_angle;
	logic signed [13:0] pitch_angle;
	logic [14:0] yaw_angle;
	logic pitch_clamped;

	int errors, pending, checked, clamp_seen;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit long_hold = 1'b0;
	int sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	quaternion_to_euler_degrees u_dut (.*);

	quat_euler_checker #(.ITERATIONS(CORDIC_ITERATIONS_DEF)) u_check (.*);

	// receiver: random stall, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				euler_stall <= 1'b1;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
				euler_stall <= 1'b0;
			end else begin
				euler_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	task automatic send_quat(int w, int x, int y, int z);
		while ($urandom_range(99) < send_idle_pct) begin
			quat_valid <= 1'b0;
			@(posedge clk);
		end
		quat_valid <= 1'b1;
		quat_w <= w[15:0];
		quat_x <= x[15:0];
		quat_y <= y[15:0];
		quat_z <= z[15:0];
		do @(posedge clk); while (quat_stall);
		sent++;
	endtask

	// random rotation, normalized to Q2.14; sometimes pushed toward gimbal lock
	task automatic send_rotation();
		real c[4], n;
		for (int i = 0; i < 4; i++)
			c[i] = real'($urandom_range(65535)) - 32768.0;
		if ($urandom_range(9) == 0) begin
			c[2] = ($urandom_range(1) ? 1.0 : -1.0) * c[0] + real'($urandom_range(64)) - 32.0;
			c[1] = ($urandom_range(1) ? 1.0 : -1.0) * c[3] + real'($urandom_range(64)) - 32.0;
		end
		n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
		if (n < 1.0)
			n = 1.0;
		send_quat($rtoi(c[0] * 16384.0 / n), $rtoi(c[1] * 16384.0 / n),
			$rtoi(c[2] * 16384.0 / n), $rtoi(c[3] * 16384.0 / n));
	endtask

	task automatic random_phase(int count);
		repeat (count) begin
			if ($urandom_range(9) < 8)
				send_rotation();
			else
				send_quat($urandom, $urandom, $urandom, $urandom);
		end
	endtask

	task automatic drain();
		quat_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_quat(0, 0, 0, 0);
		send_quat(16384, 0, 0, 0);
		send_quat(-16384, 0, 0, 0);
		send_quat(0, 16384, 0, 0);         // roll at +180
		send_quat(0, 0, 0, 16384);         // yaw at +180
		send_quat(11585, 11585, 0, 0);
		send_quat(11585, -11585, 0, 0);
		send_quat(11585, 0, 0, -11585);    // negative yaw wraps
		send_quat(11585, 0, 0, 11585);
		send_quat(11585, 0, 11585, 0);     // just below pitch clamp
		send_quat(11586, 0, 11586, 0);     // pitch clamps high
		send_quat(11586, 0, -11586, 0);    // pitch clamps low
		send_quat(8192, 8192, 8192, -8192);
		send_quat(0, 0, 16384, 0);
		send_quat(32767, 32767, 32767, 32767);
		send_quat(-32768, -32768, -32768, -32768);
		send_quat(32767, -32768, 32767, -32768);
		send_quat(-32768, 32767, -32768, 32767);
		send_quat(0, 32767, 32767, 0);
		send_quat(1, 0, 0, 0);
		send_quat(0, 0, 1, -1);
		send_quat(-1, -1, -1, -1);
		drain();

		send_idle_pct = 10;
		recv_idle_pct = 75;
		random_phase(570);
		drain();

		send_idle_pct = 75;
		recv_idle_pct = 10;
		random_phase(570);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		long_hold = 1'b1;
		random_phase(590);
		drain();

		repeat (80) @(posedge clk);
		$display("tb: %0d quaternions sent, %0d angle sets checked, %0d with pitch clamped",
			sent, checked, clamp_seen);
		$display("tb: three idle mixes and one long output hold-off exercised");
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#3ms;
		$display("tb: failure");
		$finish;
	end

endmodule
